### hdl/mtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_pkg
// shared types and constants for the move-to-front list
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int POS_W   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [KEY_W-1:0]  key_value;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [3:0] hit_position;
        logic [4:0] entry_count;
        logic       dropped;
    } t_result;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic capture;  // latch compare result against the incoming key
        logic insert;   // shift whole row back, key enters at the front
        logic move;     // shift cells up to the first match
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_MOVE
    } t_state;

endpackage
`default_nettype wire

### hdl/mtf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_cell
// one list position: value, valid, registered match and the match chain
// ----------------------------------------------------------------------------
module mtf_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mtf_pkg::t_cell_ctl          i_ctl,
    input  wire logic [mtf_pkg::KEY_W-1:0]   i_key,
    input  wire logic [mtf_pkg::KEY_W-1:0]   i_prev_value,
    input  wire logic                        i_prev_valid,
    input  wire logic                        i_ahead,
    output logic                             o_ahead,
    output logic                             o_first,
    output logic [mtf_pkg::KEY_W-1:0]        o_value,
    output logic                             o_valid
);

    logic [mtf_pkg::KEY_W-1:0] r_value;
    logic                      r_valid;
    logic                      r_match;
    logic                      w_shift;

    // a match further ahead stops the move from reaching this cell
    assign o_ahead = i_ahead | r_match;
    assign o_first = r_match & ~i_ahead;
    assign w_shift = i_ctl.insert | (i_ctl.move & ~i_ahead);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_match <= r_valid && (r_value == i_key);
            end
            if (i_ctl.insert) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_value <= i_prev_value;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

### hdl/move_to_front_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_front_list
// ordered list of up to DEPTH 32-bit values with move-to-front search
// ----------------------------------------------------------------------------
// A transaction is taken on start while busy is low; busy is high for the
// following cycle, and the result is shown with o_done for one cycle right
// after that, while busy is already low again so a new start may be taken
// in the same cycle. On acceptance every cell of the row registers a 32-bit
// compare; while busy, the first-match chain runs through the row and the
// cells shift. The receiver cannot stall: o_done lasts exactly one cycle and
// o_result is only meaningful while it is high. Inserts put the key at the
// front and push every entry back one cell, the tail entry is lost
// (dropped=1) when the list is full. Searches move the entry nearest the
// front that equals the key to the front; misses leave the list unchanged.
// hit_position and entry_count wrap to 4 and 5 bits.
// ----------------------------------------------------------------------------
module move_to_front_list (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire mtf_pkg::t_cmd    i_cmd,
    output logic                  busy,
    output logic                  o_done,
    output mtf_pkg::t_result      o_result
);

    localparam int DEPTH   = mtf_pkg::DEPTH;
    localparam int POS_W   = mtf_pkg::POS_W;
    localparam int COUNT_W = mtf_pkg::COUNT_W;

    // control
    mtf_pkg::t_state    r_state;
    mtf_pkg::t_state    n_state;
    mtf_pkg::t_cell_ctl w_ctl;
    logic               w_accept;

    // latched transaction
    logic                      r_mode;
    logic [mtf_pkg::KEY_W-1:0] r_key;

    // cell row
    logic [mtf_pkg::KEY_W-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]          w_valid;
    logic [DEPTH-1:0]          w_first;
    logic [DEPTH:0]            w_ahead;
    logic                      w_hit;

    // bookkeeping
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [POS_W-1:0]   w_pos;
    logic [31:0]        w_pos_ext;
    logic [31:0]        w_count_ext;

    // result
    logic               r_done;
    mtf_pkg::t_result   r_result;
    mtf_pkg::t_result   n_result;

    assign w_accept = start && !busy;

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mtf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = mtf_pkg::ST_MOVE;
                end
            end
            mtf_pkg::ST_MOVE: begin
                n_state = mtf_pkg::ST_IDLE;
            end
            default: begin
                n_state = mtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy          = 1'b0;
        w_ctl.capture = 1'b0;
        w_ctl.insert  = 1'b0;
        w_ctl.move    = 1'b0;
        case (r_state)
            mtf_pkg::ST_IDLE: begin
                w_ctl.capture = w_accept;
            end
            mtf_pkg::ST_MOVE: begin
                busy         = 1'b1;
                w_ctl.insert = (r_mode == mtf_pkg::MODE_INSERT);
                w_ctl.move   = (r_mode == mtf_pkg::MODE_SEARCH) && w_hit;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // key and mode held for the shift cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_cmd.mode;
            r_key  <= i_cmd.key_value;
        end
    end

    // ------------------------------------------------------------------
    // cell row: the front cell takes the key, every other cell takes
    // its neighbor ahead; the match chain runs front to back
    // ------------------------------------------------------------------
    assign w_ahead[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [mtf_pkg::KEY_W-1:0] w_prev_value;
        logic                      w_prev_valid;

        if (g == 0) begin : g_front
            // compare uses the incoming key, the shift uses the latched one
            assign w_prev_value = r_key;
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_value = w_value[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        mtf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (i_cmd.key_value),
            .i_prev_value (w_prev_value),
            .i_prev_valid (w_prev_valid),
            .i_ahead      (w_ahead[g]),
            .o_ahead      (w_ahead[g+1]),
            .o_first      (w_first[g]),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g])
        );
    end

    assign w_hit = w_ahead[DEPTH];

    // first-match position, at most one bit of w_first is set
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
        end
    end

    // entry count tracks the valid prefix, saturating when full
    always_comb begin
        n_count = r_count;
        if (w_ctl.insert && (r_count != COUNT_W'(DEPTH))) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign w_pos_ext   = 32'(w_pos);
    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_result.hit          = 1'b0;
        n_result.hit_position = 4'd0;
        n_result.entry_count  = w_count_ext[4:0];
        n_result.dropped      = 1'b0;
        if (r_mode == mtf_pkg::MODE_INSERT) begin
            // tail valid before the shift means it falls off
            n_result.dropped = w_valid[DEPTH-1];
        end else if (w_hit) begin
            n_result.hit          = 1'b1;
            n_result.hit_position = w_pos_ext[3:0];
        end
    end

    // result strobe, raised in the cycle after the shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == mtf_pkg::ST_MOVE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mtf_pkg::ST_MOVE) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // valid cells always form a prefix from the front
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("valid cells are not a prefix");

    // entry counter agrees with the valid bits
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("entry count out of step with valid cells");

    // every accepted transaction is followed by its o_done strobe once the busy state is over
    a_done_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_done)
        else $error("result strobe missing after accepted transaction");

    // at most one cell can be the first match
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match in the row");

endmodule
`default_nettype wire
